// File: src/stbs_pkg.sv
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and constants for the sorted table binary search block.
// ----------------------------------------------------------------------------
package stbs_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;

    localparam int IDX_W   = 10;   // entry_index, window_low, match_index
    localparam int DATA_W  = 32;   // table word and search key
    localparam int HIGH_W  = 11;   // window_high, signed
    localparam int POS_W   = 12;   // signed window bound, holds -1 .. 1024

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 16;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SEARCH = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // write one table entry from the input item
        logic start;      // latch key and window, issue first probe read
        logic step;       // narrow the window, issue next probe read
        logic finish;     // capture the search result
        logic hit;        // result is a match at the current probe
        logic out_load;   // move the captured result to the output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic win_empty;  // incoming window is empty after saturation
        logic hit;        // probed entry equals the key
        logic exhausted;  // no entry left on the side the key points to
    } status_t;

endpackage

// File: src/stbs_ram.sv
// ----------------------------------------------------------------------------
// stbs_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/stbs_ctrl.sv
// ----------------------------------------------------------------------------
// stbs_ctrl
// Controller for the binary search: accepts items, sequences the probes and
// owns the output valid flag.
// ----------------------------------------------------------------------------
module stbs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_valid,
    input  logic              s_opcode,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  stbs_pkg::status_t status,
    output stbs_pkg::cmd_t    cmd
);

    import stbs_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        s_ready        = 1'b0;
        out_valid_next = out_valid_reg && !m_ready;

        unique case (state_reg)
            S_IDLE:
            begin
                s_ready = 1'b1;
                if (s_valid)
                begin
                    if (s_opcode == OP_LOAD)
                    begin
                        cmd.load = 1'b1;
                    end
                    else
                    begin
                        cmd.start = 1'b1;
                        if (status.win_empty)
                        begin
                            cmd.finish = 1'b1;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_PROBE;
                        end
                    end
                end
            end

            S_PROBE:
            begin
                if (status.hit)
                begin
                    cmd.finish = 1'b1;
                    cmd.hit    = 1'b1;
                    state_next = S_DONE;
                end
                else if (status.exhausted)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end

            S_DONE:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || m_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid = out_valid_reg;

endmodule

// File: src/stbs_dp.sv
// ----------------------------------------------------------------------------
// stbs_dp
// Datapath for the binary search: table RAM, window bounds, midpoint
// arithmetic, key compare and result registers.
// ----------------------------------------------------------------------------
module stbs_dp #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                clk,
    input  stbs_pkg::cmd_t                      cmd,
    input  logic        [stbs_pkg::IDX_W-1:0]   entry_index,
    input  logic signed [stbs_pkg::DATA_W-1:0]  data_value,
    input  logic        [stbs_pkg::IDX_W-1:0]   window_low,
    input  logic signed [stbs_pkg::HIGH_W-1:0]  window_high,
    output stbs_pkg::status_t                   status,
    output logic                                found,
    output logic        [stbs_pkg::IDX_W-1:0]   match_index
);

    import stbs_pkg::*;

    localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int IDX_MAX = (1 << IDX_W) - 1;
    localparam int HI_MAX = (TABLE_DEPTH - 1 < IDX_MAX) ? TABLE_DEPTH - 1 : IDX_MAX;
    localparam logic signed [POS_W-1:0] HI_LIM  = POS_W'(HI_MAX);
    localparam logic signed [POS_W-1:0] POS_ONE = POS_W'(1);

    logic signed [DATA_W-1:0] key_reg;
    logic signed [POS_W-1:0]  lo_reg;
    logic signed [POS_W-1:0]  hi_reg;
    logic        [IDX_W-1:0]  mid_reg;
    logic                     res_found_reg;
    logic        [IDX_W-1:0]  res_idx_reg;
    logic                     out_found_reg;
    logic        [IDX_W-1:0]  out_idx_reg;

    logic signed [POS_W-1:0]  lo0;
    logic signed [POS_W-1:0]  hi_ext;
    logic signed [POS_W-1:0]  hi0;
    logic signed [POS_W-1:0]  sum0;
    logic        [IDX_W-1:0]  mid0;
    logic signed [POS_W-1:0]  mid_pos;
    logic signed [POS_W-1:0]  sum_lt;
    logic signed [POS_W-1:0]  sum_gt;
    logic        [IDX_W-1:0]  mid_step;
    logic        [DATA_W-1:0] rdata;
    logic signed [DATA_W-1:0] entry;
    logic                     key_lt;
    logic                     we;
    logic        [AW-1:0]     raddr;

    // incoming window, high bound clamped to the last table position
    assign lo0    = {{(POS_W - IDX_W){1'b0}}, window_low};
    assign hi_ext = {{(POS_W - HIGH_W){window_high[HIGH_W-1]}}, window_high};
    assign hi0    = (hi_ext > HI_LIM) ? HI_LIM : hi_ext;
    assign sum0   = lo0 + hi0;
    assign mid0   = sum0[IDX_W:1];

    // both candidate midpoints are formed from registers; the compare picks one
    assign entry   = $signed(rdata);
    assign key_lt  = key_reg < entry;
    assign mid_pos = {{(POS_W - IDX_W){1'b0}}, mid_reg};
    assign sum_lt  = lo_reg + mid_pos - POS_ONE;
    assign sum_gt  = mid_pos + POS_ONE + hi_reg;
    assign mid_step = key_lt ? sum_lt[IDX_W:1] : sum_gt[IDX_W:1];

    assign status.win_empty = lo0 > hi0;
    assign status.hit       = key_reg == entry;
    assign status.exhausted = key_lt ? (mid_pos == lo_reg) : (mid_pos == hi_reg);

    assign we    = cmd.load && (32'(entry_index) < 32'(TABLE_DEPTH));
    assign raddr = cmd.start ? AW'(mid0) : AW'(mid_step);

    stbs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (AW'(entry_index)),
        .wdata (data_value),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_reg <= data_value;
            lo_reg  <= lo0;
            hi_reg  <= hi0;
            mid_reg <= mid0;
        end
        else if (cmd.step)
        begin
            mid_reg <= mid_step;
            if (key_lt)
            begin
                hi_reg <= mid_pos - POS_ONE;
            end
            else
            begin
                lo_reg <= mid_pos + POS_ONE;
            end
        end

        if (cmd.finish)
        begin
            res_found_reg <= cmd.hit;
            res_idx_reg   <= cmd.hit ? mid_reg : '0;
        end

        if (cmd.out_load)
        begin
            out_found_reg <= res_found_reg;
            out_idx_reg   <= res_idx_reg;
        end
    end

    assign found       = out_found_reg;
    assign match_index = out_idx_reg;

endmodule

// File: src/sorted_table_binary_search.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Table of signed 32-bit words with load and binary search items.
// ----------------------------------------------------------------------------
// A load item (tuser = 0) writes one table entry and gives
// no result; loads at or beyond the table depth are dropped. A search item
// (tuser = 1) halves the inclusive window [window_low, window_high] (high
// clamped to the last entry) and returns one result: found in tuser and the
// match position in tdata, or zero position when the key is absent. A search
// makes P probes (at most 11 for a full 1024-entry window, none for an empty
// window), one probe per cycle on the table RAM's single registered read
// port, once the item is accepted, and the result then moves to the output
// register once it is free. Entries the search reads must have been loaded,
// in ascending order. The input is taken again while a result still waits
// on the output.
module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // entry_index[9:0], data_value[41:10], window_low[51:42],
    // window_high[62:52], zero[63]
    input  logic [stbs_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // opcode[0]
    input  logic [0:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // match_index[9:0], zero[15:10]
    output logic [stbs_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // found[0]
    output logic [0:0]                       m_axis_tuser
);

    import stbs_pkg::*;

    localparam int DV_LSB = IDX_W;
    localparam int WL_LSB = DV_LSB + DATA_W;
    localparam int WH_LSB = WL_LSB + IDX_W;

    cmd_t                     cmd;
    status_t                  status;
    logic                     found;
    logic        [IDX_W-1:0]  match_index;

    stbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_valid  (s_axis_tvalid),
        .s_opcode (s_axis_tuser[0]),
        .s_ready  (s_axis_tready),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    stbs_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk         (clk),
        .cmd         (cmd),
        .entry_index (s_axis_tdata[IDX_W-1:0]),
        .data_value  ($signed(s_axis_tdata[DV_LSB +: DATA_W])),
        .window_low  (s_axis_tdata[WL_LSB +: IDX_W]),
        .window_high ($signed(s_axis_tdata[WH_LSB +: HIGH_W])),
        .status      (status),
        .found       (found),
        .match_index (match_index)
    );

    assign m_axis_tdata = {{(M_TDATA_W - IDX_W){1'b0}}, match_index};
    assign m_axis_tuser = found;

    // a miss always reports position zero
    a_miss_zero_index: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[IDX_W-1:0] == '0)
    ) else $error("miss result with nonzero position");

    // a hit lies inside the table
    a_hit_in_table: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0])
            |-> (32'(m_axis_tdata[IDX_W-1:0]) < 32'(TABLE_DEPTH))
    ) else $error("hit position beyond table depth");

    // a load never produces a result
    a_load_no_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == OP_LOAD))
            |=> !$rose(m_axis_tvalid)
    ) else $error("result raised after a load item");

endmodule
